// File: hw/rtl/cvmp_pkg.sv
// Shared types, widths and constants of the CORDIC magnitude and phase pipeline.
package cvmp_pkg;

	localparam int DATA_WIDTH     = 16;
	localparam int ITERATIONS_DEF = 15;
	localparam int ITERATIONS_MAX = 16;

	// Wide enough for the CORDIC gain of about 1.65 on a folded full-scale input.
	localparam int XW = DATA_WIDTH + 4;
	// Phase accumulator with 16 fractional bits, covering about -pi/2 to 3pi/2.
	localparam int AW = 21;
	localparam int ANG_SHIFT = 4;

	localparam int GAIN_W = 17;
	localparam logic signed [GAIN_W-1:0] GAIN_Q16    = 17'sd39797;
	localparam logic signed [AW-1:0]     HALF_PI_Q16 = 21'sd102944;
	localparam logic signed [AW-1:0]     PI_Q16      = 21'sd205887;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] real_part;
		logic signed [DATA_WIDTH-1:0] imag_part;
	} sample_t;

	typedef struct packed {
		logic        [DATA_WIDTH-1:0] magnitude;
		logic signed [DATA_WIDTH-1:0] angle;
	} result_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [AW-1:0] th;
	} vec_t;

	// atan(2^-i) in radians with 16 fractional bits, rounded to nearest.
	function automatic logic signed [AW-1:0] atan_q16(input logic [3:0] idx);
		logic signed [AW-1:0] r;
		unique case (idx)
			4'd0:    r = 21'sd51472;
			4'd1:    r = 21'sd30386;
			4'd2:    r = 21'sd16055;
			4'd3:    r = 21'sd8150;
			4'd4:    r = 21'sd4091;
			4'd5:    r = 21'sd2047;
			4'd6:    r = 21'sd1024;
			4'd7:    r = 21'sd512;
			4'd8:    r = 21'sd256;
			4'd9:    r = 21'sd128;
			4'd10:   r = 21'sd64;
			4'd11:   r = 21'sd32;
			4'd12:   r = 21'sd16;
			4'd13:   r = 21'sd8;
			4'd14:   r = 21'sd4;
			default: r = 21'sd2;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/cvmp_prerot.sv
// Input stage that folds a sample into the right half plane and seeds the phase.
module cvmp_prerot (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_in,
	input  cvmp_pkg::sample_t sample_in,
	output logic             vld_out,
	output cvmp_pkg::vec_t   vec_out
);
	import cvmp_pkg::*;

	logic signed [XW-1:0] xe;
	logic signed [XW-1:0] ye;
	vec_t                 vec_d;
	vec_t                 vec_s1;
	logic                 vld_s1;

	assign xe = XW'(sample_in.real_part);
	assign ye = XW'(sample_in.imag_part);

	// A negative real part with zero imaginary part takes the second-quadrant path.
	always_comb begin
		priority if (xe < 0 && ye >= 0) begin
			vec_d.x  = ye;
			vec_d.y  = -xe;
			vec_d.th = HALF_PI_Q16;
		end else if (xe < 0) begin
			vec_d.x  = -xe;
			vec_d.y  = -ye;
			vec_d.th = PI_Q16;
		end else begin
			vec_d.x  = xe;
			vec_d.y  = ye;
			vec_d.th = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vec_d;
	end

	assign vld_out = vld_s1;
	assign vec_out = vec_s1;

endmodule

// File: hw/rtl/cvmp_stage.sv
// One registered CORDIC vectoring micro-rotation with a fixed shift.
module cvmp_stage #(
	parameter int SHIFT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_in,
	input  cvmp_pkg::vec_t vec_in,
	output logic           vld_out,
	output cvmp_pkg::vec_t vec_out
);
	import cvmp_pkg::*;

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [AW-1:0] step;
	vec_t                 vec_d;
	vec_t                 vec_s1;
	logic                 vld_s1;

	// Arithmetic shifts round toward minus infinity, as the format requires.
	assign xs   = vec_in.x >>> SHIFT;
	assign ys   = vec_in.y >>> SHIFT;
	assign step = atan_q16(4'(SHIFT));

	always_comb begin
		if (!vec_in.y[XW-1]) begin
			vec_d.x  = vec_in.x + ys;
			vec_d.y  = vec_in.y - xs;
			vec_d.th = vec_in.th + step;
		end else begin
			vec_d.x  = vec_in.x - ys;
			vec_d.y  = vec_in.y + xs;
			vec_d.th = vec_in.th - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vec_d;
	end

	assign vld_out = vld_s1;
	assign vec_out = vec_s1;

endmodule

// File: hw/rtl/cvmp_scale.sv
// Output stages: gain multiply and phase truncation, then clamp of the magnitude.
module cvmp_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  cvmp_pkg::vec_t    vec_in,
	output logic              vld_out,
	output cvmp_pkg::result_t res_out
);
	import cvmp_pkg::*;

	localparam int PW = XW + GAIN_W;

	logic signed [PW-1:0]         prod_s1;
	logic signed [DATA_WIDTH-1:0] ang_s1;
	logic                         vld_s1;
	result_t                      res_d;
	result_t                      res_s2;
	logic                         vld_s2;

	always_comb begin
		res_d.angle = ang_s1;
		priority if (prod_s1[PW-1]) begin
			res_d.magnitude = '0;
		end else if (|prod_s1[PW-2:DATA_WIDTH+16]) begin
			res_d.magnitude = '1;
		end else begin
			res_d.magnitude = prod_s1[DATA_WIDTH+15:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(vec_in.x) * PW'(GAIN_Q16);
		ang_s1  <= vec_in.th[DATA_WIDTH+ANG_SHIFT-1:ANG_SHIFT];
		res_s2  <= res_d;
	end

	assign vld_out = vld_s2;
	assign res_out = res_s2;

endmodule

// File: hw/rtl/cordic_vector_magnitude_phase.sv
// CORDIC vectoring pipeline: magnitude and phase of one complex sample per clock.
// Throughput: one transaction every cycle; busy is always low, since the fixed
// pipeline of one fold stage, ITERATIONS rotation stages and two scaling stages never stalls.
// Reset: arst_n clears only the valid bits; data registers are not reset.
// The receiver cannot stall: each result is shown for one cycle while done is high.
module cordic_vector_magnitude_phase #(
	parameter int ITERATIONS = cvmp_pkg::ITERATIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cvmp_pkg::sample_t sample,
	output logic              done,
	output cvmp_pkg::result_t result
);
	import cvmp_pkg::*;

	// Stage k of these arrays is the output of the k-th register stage after the fold.
	vec_t vec_p [ITERATIONS+1];
	logic vld_p [ITERATIONS+1];

	// The pipeline advances every cycle, so a new transaction is always taken.
	assign busy = 1'b0;

	// Fold second- and third-quadrant samples into the right half plane.
	cvmp_prerot u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_in    (start),
		.sample_in (sample),
		.vld_out   (vld_p[0]),
		.vec_out   (vec_p[0])
	);

	// One micro-rotation per stage; stage i shifts by i and uses atan(2^-i).
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
		cvmp_stage #(
			.SHIFT (i)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_p[i]),
			.vec_in  (vec_p[i]),
			.vld_out (vld_p[i+1]),
			.vec_out (vec_p[i+1])
		);
	end

	// Remove the CORDIC gain, clamp the magnitude and cut the phase to 12 fractional bits.
	cvmp_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_p[ITERATIONS]),
		.vec_in  (vec_p[ITERATIONS]),
		.vld_out (done),
		.res_out (result)
	);

endmodule
